### rtl/scfp_pkg.sv
// Package for the serial command frame parser: field widths, stream packing
// offsets, register indexes and dispatch action codes. No dependencies.
`default_nettype none

package scfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned ActionW = 3;
  localparam int unsigned PhaseW  = 3;

  // Result tdata layout, lowest bit first
  localparam int unsigned OutDataW  = 80;
  localparam int unsigned PvLo      = 0;
  localparam int unsigned PposLo    = 8;
  localparam int unsigned CmdLo     = 24;
  localparam int unsigned FlenLo    = 32;
  localparam int unsigned ActLo     = 48;
  localparam int unsigned AvalLo    = 51;
  localparam int unsigned AckBit    = 59;
  localparam int unsigned StatLo    = 60;
  localparam int unsigned CsOkBit   = 68;
  localparam int unsigned RxCsLo    = 69;
  localparam int unsigned UsedW     = 77;

  // Configuration port
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;
  localparam logic [1:0]  RegStart   = 2'd0;
  localparam logic [1:0]  RegMaxLen  = 2'd1;
  localparam logic [1:0]  RegCsEnf   = 2'd2;

  localparam logic [ByteW-1:0] StartReset  = 8'hA5;
  localparam logic [LenW-1:0]  MaxLenReset = 16'd2000;
  localparam logic [ByteW-1:0] StatUnknown = 8'hFF;

  // Command bytes
  localparam logic [ByteW-1:0] CmdPing     = 8'h01;
  localparam logic [ByteW-1:0] CmdChannel  = 8'h02;
  localparam logic [ByteW-1:0] CmdTransmit = 8'h03;
  localparam logic [ByteW-1:0] CmdSniffer  = 8'h04;
  localparam logic [ByteW-1:0] CmdScan     = 8'h05;

  // Dispatch actions
  localparam logic [ActionW-1:0] ActPing     = 3'd0;
  localparam logic [ActionW-1:0] ActChannel  = 3'd1;
  localparam logic [ActionW-1:0] ActTransmit = 3'd2;
  localparam logic [ActionW-1:0] ActSniffer  = 3'd3;
  localparam logic [ActionW-1:0] ActScan     = 3'd4;
  localparam logic [ActionW-1:0] ActUnknown  = 3'd5;
  localparam logic [ActionW-1:0] ActIgnored  = 3'd6;
  localparam logic [ActionW-1:0] ActCsDrop   = 3'd7;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

endpackage

`default_nettype wire

### rtl/serial_command_frame_parser_unit.sv
// Serial command frame parser top level: frame state machine, dispatch
// decode, output register and APB configuration registers. Uses scfp_pkg.
`default_nettype none

// Takes one received byte per transaction on the slave stream and parses
// frames of start byte, command, 16-bit little-endian length, payload and an
// XOR checksum byte. Every payload byte leaves as a result with tuser = 0;
// the checksum byte closes the frame with a result with tuser = 1 carrying
// command, length, checksum verdict and dispatch action. Header bytes and
// oversize frames give no result. The block takes one byte per cycle: the
// parse state updates in the cycle a byte is accepted and its result sits in
// a single output register, so a byte is taken whenever that register is
// empty or is being drained in the same cycle. A result appears in the cycle
// after its byte. Registers: 0x0 start marker, 0x4 max payload length,
// 0x8 checksum enforce; write them only while no frame is in flight.
module serial_command_frame_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] payload_value, [23:8] payload_position, [31:24] frame_cmd,
  // [47:32] frame_len, [50:48] action, [58:51] action_value, [59] host_ack,
  // [67:60] ack_status, [68] checksum_ok, [76:69] received_checksum, zero pad
  output      logic [79:0] m_axis_tdata,
  output      logic        m_axis_tuser,   // [0] item_kind
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam logic [scfp_pkg::PhaseW-1:0] PhIdle   = 3'd0;
  localparam logic [scfp_pkg::PhaseW-1:0] PhCmd    = 3'd1;
  localparam logic [scfp_pkg::PhaseW-1:0] PhLenLo  = 3'd2;
  localparam logic [scfp_pkg::PhaseW-1:0] PhLenHi  = 3'd3;
  localparam logic [scfp_pkg::PhaseW-1:0] PhData   = 3'd4;
  localparam logic [scfp_pkg::PhaseW-1:0] PhCsum   = 3'd5;

  // configuration
  logic [7:0]  start_q;
  logic [15:0] max_len_q;
  logic        cs_enf_q;
  logic        cfg_wr;

  // parse state
  logic [scfp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  first_q, first_d;

  // output register
  logic        out_vld_q, out_vld_d;
  logic        kind_q, kind_d;
  logic [scfp_pkg::UsedW-1:0] res_q, res_d;

  logic        in_acc;
  logic        has_res;
  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  // frame end decode
  logic                          cs_ok;
  logic                          has_data;
  logic [scfp_pkg::ActionW-1:0]  act;
  logic                          ack;
  logic [7:0]                    stat;
  logic [7:0]                    aval;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      scfp_pkg::RegStart:  prdata = {24'd0, start_q};
      scfp_pkg::RegMaxLen: prdata = {16'd0, max_len_q};
      scfp_pkg::RegCsEnf:  prdata = {31'd0, cs_enf_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= scfp_pkg::StartReset;
      max_len_q <= scfp_pkg::MaxLenReset;
      cs_enf_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        scfp_pkg::RegStart:  start_q   <= pwdata[7:0];
        scfp_pkg::RegMaxLen: max_len_q <= pwdata[15:0];
        scfp_pkg::RegCsEnf:  cs_enf_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Take a byte whenever the output register is free or drains this cycle
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign cnt_inc       = cnt_q + 16'd1;
  assign len_full      = {b, len_q[7:0]};

  always_comb begin
    cs_ok    = (b == xor_q);
    has_data = (len_q != 16'd0);
    act      = scfp_pkg::ActUnknown;
    ack      = 1'b0;
    stat     = 8'd0;
    aval     = 8'd0;
    if (cs_enf_q && !cs_ok) begin
      act = scfp_pkg::ActCsDrop;
    end else begin
      case (cmd_q)
        scfp_pkg::CmdPing: begin
          act = scfp_pkg::ActPing;
          ack = 1'b1;
        end
        scfp_pkg::CmdChannel:
          act = has_data ? scfp_pkg::ActChannel : scfp_pkg::ActIgnored;
        scfp_pkg::CmdTransmit:
          act = scfp_pkg::ActTransmit;
        scfp_pkg::CmdSniffer:
          act = has_data ? scfp_pkg::ActSniffer : scfp_pkg::ActIgnored;
        scfp_pkg::CmdScan:
          act = has_data ? scfp_pkg::ActScan : scfp_pkg::ActIgnored;
        default: begin
          act  = scfp_pkg::ActUnknown;
          ack  = 1'b1;
          stat = scfp_pkg::StatUnknown;
        end
      endcase
      if (act inside {scfp_pkg::ActChannel, scfp_pkg::ActSniffer, scfp_pkg::ActScan}) begin
        ack  = 1'b1;
        aval = first_q;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    first_d = first_q;
    has_res = 1'b0;
    kind_d  = scfp_pkg::KindPayload;
    res_d   = '0;
    res_d[scfp_pkg::CmdLo  +: 8]  = cmd_q;
    res_d[scfp_pkg::FlenLo +: 16] = len_q;
    case (phase_q)
      PhCmd: begin
        cmd_d   = b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {8'd0, b};
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d = len_full;
        if (len_full > max_len_q) begin
          phase_d = PhIdle;
        end else begin
          cnt_d   = 16'd0;
          xor_d   = 8'd0;
          first_d = 8'd0;
          phase_d = (len_full == 16'd0) ? PhCsum : PhData;
        end
      end
      PhData: begin
        if (cnt_q == 16'd0) first_d = b;
        has_res = 1'b1;
        res_d[scfp_pkg::PvLo   +: 8]  = b;
        res_d[scfp_pkg::PposLo +: 16] = cnt_q;
        xor_d = xor_q ^ b;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) phase_d = PhCsum;
      end
      PhCsum: begin
        has_res = 1'b1;
        kind_d  = scfp_pkg::KindFrameEnd;
        res_d[scfp_pkg::ActLo  +: scfp_pkg::ActionW] = act;
        res_d[scfp_pkg::AvalLo +: 8] = aval;
        res_d[scfp_pkg::AckBit]      = ack;
        res_d[scfp_pkg::StatLo +: 8] = stat;
        res_d[scfp_pkg::CsOkBit]     = cs_ok;
        res_d[scfp_pkg::RxCsLo +: 8] = b;
        phase_d = PhIdle;
      end
      default: begin
        // idle and the unused codes wait for the start byte
        phase_d = (b == start_q) ? PhCmd : PhIdle;
      end
    endcase
  end

  assign out_vld_d = (in_acc && has_res) || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      cmd_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      xor_q     <= '0;
      first_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        xor_q   <= xor_d;
        first_q <= first_d;
      end
    end
  end

  // result payload: load only with a new result
  always_ff @(posedge clk_i) begin
    if (in_acc && has_res) begin
      kind_q <= kind_d;
      res_q  <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {{(scfp_pkg::OutDataW - scfp_pkg::UsedW){1'b0}}, res_q};

  // parse phase never leaves the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q <= PhCsum)
    else $error("parse phase out of range");

  // while in the payload phase the count stays below the declared length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (cnt_q < len_q))
    else $error("payload count reached length in payload phase");

  // a frame end without acknowledge carries zero status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == scfp_pkg::KindFrameEnd && !res_q[scfp_pkg::AckBit])
      |-> (res_q[scfp_pkg::StatLo +: 8] == 8'd0))
    else $error("ack status without acknowledge");

  // a checksum drop only happens on a mismatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == scfp_pkg::KindFrameEnd &&
     res_q[scfp_pkg::ActLo +: scfp_pkg::ActionW] == scfp_pkg::ActCsDrop)
      |-> !res_q[scfp_pkg::CsOkBit])
    else $error("checksum drop with good checksum");

endmodule

`default_nettype wire

### bench/serial_command_frame_parser_unit_test.sv
// Testbench for serial_command_frame_parser_unit: drives serial bytes and APB
// register writes, and checks every result against a frame-level predictor.
// Depends on scfp_pkg and the serial_command_frame_parser_unit RTL.
`default_nettype none

module serial_command_frame_parser_unit_test;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int MaxPrinted = 50;

  typedef enum logic [scfp_pkg::PhaseW-1:0] {
    PhWaitStart = 3'd0,
    PhCommand   = 3'd1,
    PhLenLow    = 3'd2,
    PhLenHigh   = 3'd3,
    PhPayload   = 3'd4,
    PhChecksum  = 3'd5
  } parse_phase_e;

  typedef struct {
    logic                         kind;
    logic [scfp_pkg::ByteW-1:0]   pval;
    logic [scfp_pkg::LenW-1:0]    ppos;
    logic [scfp_pkg::ByteW-1:0]   cmd;
    logic [scfp_pkg::LenW-1:0]    flen;
    logic [scfp_pkg::ActionW-1:0] act;
    logic [scfp_pkg::ByteW-1:0]   aval;
    logic                         ack;
    logic [scfp_pkg::ByteW-1:0]   stat;
    logic                         csok;
    logic [scfp_pkg::ByteW-1:0]   rxcs;
  } parser_result_t;

  // Tracks the frame state and configuration, holds the expected results.
  class parser_scoreboard;
    logic [scfp_pkg::ByteW-1:0] marker  = scfp_pkg::StartReset;
    logic [scfp_pkg::LenW-1:0]  max_len = scfp_pkg::MaxLenReset;
    logic                       enforce = 1'b0;
    parse_phase_e               phase   = PhWaitStart;
    logic [scfp_pkg::ByteW-1:0] cmd_q   = '0;
    logic [scfp_pkg::LenW-1:0]  len_q   = '0;
    logic [scfp_pkg::LenW-1:0]  count_q = '0;
    logic [scfp_pkg::ByteW-1:0] xor_q   = '0;
    logic [scfp_pkg::ByteW-1:0] first_q = '0;
    parser_result_t             pending_q[$];
    int                         errors  = 0;

    task report_mismatch(string msg);
      if (errors < MaxPrinted) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return pending_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [scfp_pkg::PdataW-1:0] val);
      case (idx)
        scfp_pkg::RegStart:  marker  = val[scfp_pkg::ByteW-1:0];
        scfp_pkg::RegMaxLen: max_len = val[scfp_pkg::LenW-1:0];
        scfp_pkg::RegCsEnf:  enforce = val[0];
        default: ;
      endcase
    endfunction

    function parser_result_t blank_result();
      parser_result_t r;
      r = '{default: '0};
      r.cmd  = cmd_q;
      r.flen = len_q;
      return r;
    endfunction

    function parser_result_t predict_frame_end(logic [scfp_pkg::ByteW-1:0] csum);
      parser_result_t r;
      logic ok;
      logic has_data;
      r = blank_result();
      ok = (csum == xor_q);
      has_data = (len_q != 0);
      r.kind = scfp_pkg::KindFrameEnd;
      r.csok = ok;
      r.rxcs = csum;
      if (enforce && !ok) begin
        r.act = scfp_pkg::ActCsDrop;
      end else begin
        case (cmd_q)
          scfp_pkg::CmdPing: begin
            r.act = scfp_pkg::ActPing;
            r.ack = 1'b1;
          end
          scfp_pkg::CmdChannel:
            r.act = has_data ? scfp_pkg::ActChannel : scfp_pkg::ActIgnored;
          scfp_pkg::CmdTransmit:
            r.act = scfp_pkg::ActTransmit;
          scfp_pkg::CmdSniffer:
            r.act = has_data ? scfp_pkg::ActSniffer : scfp_pkg::ActIgnored;
          scfp_pkg::CmdScan:
            r.act = has_data ? scfp_pkg::ActScan : scfp_pkg::ActIgnored;
          default: begin
            r.act  = scfp_pkg::ActUnknown;
            r.ack  = 1'b1;
            r.stat = scfp_pkg::StatUnknown;
          end
        endcase
        if (r.act inside {scfp_pkg::ActChannel, scfp_pkg::ActSniffer,
                          scfp_pkg::ActScan}) begin
          r.ack  = 1'b1;
          r.aval = first_q;
        end
      end
      return r;
    endfunction

    function void note_rx_byte(logic [scfp_pkg::ByteW-1:0] b);
      parser_result_t r;
      case (phase)
        PhCommand: begin
          cmd_q = b;
          phase = PhLenLow;
        end
        PhLenLow: begin
          len_q = {8'h00, b};
          phase = PhLenHigh;
        end
        PhLenHigh: begin
          len_q[15:8] = b;
          if (len_q > max_len) begin
            phase = PhWaitStart;
          end else begin
            count_q = '0;
            xor_q   = '0;
            first_q = '0;
            phase   = (len_q == 0) ? PhChecksum : PhPayload;
          end
        end
        PhPayload: begin
          if (count_q == 0) first_q = b;
          r = blank_result();
          r.kind = scfp_pkg::KindPayload;
          r.pval = b;
          r.ppos = count_q;
          pending_q.push_back(r);
          xor_q = xor_q ^ b;
          count_q = count_q + 16'd1;
          if (count_q >= len_q) phase = PhChecksum;
        end
        PhChecksum: begin
          pending_q.push_back(predict_frame_end(b));
          phase = PhWaitStart;
        end
        default: phase = (b == marker) ? PhCommand : PhWaitStart;
      endcase
    endfunction

    task compare_field(string name, logic [scfp_pkg::LenW-1:0] got,
                       logic [scfp_pkg::LenW-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic [scfp_pkg::OutDataW-1:0] d, logic u);
      parser_result_t w;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %h", d));
        return;
      end
      w = pending_q.pop_front();
      compare_field("item_kind", 16'(u), 16'(w.kind));
      compare_field("payload_value",
                    16'(d[scfp_pkg::PvLo +: scfp_pkg::ByteW]), 16'(w.pval));
      compare_field("payload_position", d[scfp_pkg::PposLo +: scfp_pkg::LenW], w.ppos);
      compare_field("frame_cmd",
                    16'(d[scfp_pkg::CmdLo +: scfp_pkg::ByteW]), 16'(w.cmd));
      compare_field("frame_len", d[scfp_pkg::FlenLo +: scfp_pkg::LenW], w.flen);
      compare_field("action",
                    16'(d[scfp_pkg::ActLo +: scfp_pkg::ActionW]), 16'(w.act));
      compare_field("action_value",
                    16'(d[scfp_pkg::AvalLo +: scfp_pkg::ByteW]), 16'(w.aval));
      compare_field("host_ack", 16'(d[scfp_pkg::AckBit]), 16'(w.ack));
      compare_field("ack_status",
                    16'(d[scfp_pkg::StatLo +: scfp_pkg::ByteW]), 16'(w.stat));
      compare_field("checksum_ok", 16'(d[scfp_pkg::CsOkBit]), 16'(w.csok));
      compare_field("received_checksum",
                    16'(d[scfp_pkg::RxCsLo +: scfp_pkg::ByteW]), 16'(w.rxcs));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [7:0] payload_value, [23:8] payload_position, [31:24] frame_cmd,
  // [47:32] frame_len, [50:48] action, [58:51] action_value, [59] host_ack,
  // [67:60] ack_status, [68] checksum_ok, [76:69] received_checksum, zero pad
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;    // [0] item_kind
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  parser_scoreboard sb;
  int tx_idle_pct = 34;
  int rx_idle_pct = 34;
  int bytes_sent  = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;

  serial_command_frame_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_rx_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Setup and access phases, then the bus is released and left idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Header, then payload and checksum if within max_len; cut >= 0 truncates the frame after cut bytes.
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                            input bit bad_csum, input int cut);
    logic [7:0] frame_q[$];
    logic [7:0] acc;
    logic [7:0] pb;
    acc = '0;
    frame_q.push_back(sb.marker);
    frame_q.push_back(cmd);
    frame_q.push_back(len[7:0]);
    frame_q.push_back(len[15:8]);
    if (len <= sb.max_len) begin
      for (int i = 0; i < int'(len); i++) begin
        pb = 8'($urandom_range(0, 255));
        acc = acc ^ pb;
        frame_q.push_back(pb);
      end
      frame_q.push_back(bad_csum ? acc ^ 8'($urandom_range(1, 255)) : acc);
    end
    foreach (frame_q[i])
      if (cut < 0 || i < cut) send_byte(frame_q[i]);
  endtask

  // Mostly well-formed frames; clean drops truncation and keeps noise off the marker.
  task automatic random_frame(input bit clean);
    logic [7:0] cmd;
    logic [7:0] nb;
    int max_i;
    int len;
    int pick;
    int cut;
    max_i = sb.max_len;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        do nb = 8'($urandom_range(0, 255)); while (clean && nb == sb.marker);
        send_byte(nb);
      end
    end
    cmd = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 5)) : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      len = $urandom_range(0, (max_i < 6) ? max_i : 6);
    end else if (pick < 16) begin
      len = (max_i <= 64) ? max_i : $urandom_range(0, 6);
    end else if (pick < 18 && max_i < 65535) begin
      len = max_i + $urandom_range(1, 300);
      if (len > 65535) len = 65535;
    end else if (pick == 18 && max_i < 65535) begin
      len = 65535;
    end else begin
      len = $urandom_range(0, (max_i < 20) ? max_i : 20);
    end
    cut = (!clean && $urandom_range(0, 11) == 0) ? $urandom_range(1, 3 + len) : -1;
    send_frame(cmd, len[15:0], ($urandom_range(0, 4) == 0), cut);
  endtask

  task automatic run_random(input int budget, input bit clean);
    int stop;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) random_frame(clean);
  endtask

  // Finish any open frame, then wait until every result has drained.
  task automatic settle_idle();
    while (sb.phase != PhWaitStart) begin
      case (sb.phase)
        PhCommand:           send_byte(scfp_pkg::CmdPing);
        PhLenLow, PhLenHigh: send_byte(8'h00);
        default:             send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset configuration: every command, empty and oversize frames, noise
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(scfp_pkg::CmdPing, 16'd0, 1'b0, -1);
    send_frame(scfp_pkg::CmdPing, 16'd0, 1'b1, -1);
    send_frame(scfp_pkg::CmdChannel, 16'd0, 1'b0, -1);
    send_frame(scfp_pkg::CmdChannel, 16'd1, 1'b0, -1);
    send_frame(scfp_pkg::CmdTransmit, 16'd2, 1'b0, -1);
    send_frame(scfp_pkg::CmdSniffer, 16'd0, 1'b0, -1);
    send_frame(scfp_pkg::CmdSniffer, 16'd1, 1'b1, -1);
    send_frame(scfp_pkg::CmdScan, 16'd0, 1'b0, -1);
    send_frame(scfp_pkg::CmdScan, 16'd3, 1'b0, -1);
    send_frame(8'h00, 16'd1, 1'b0, -1);
    send_frame(8'h06, 16'd0, 1'b0, -1);
    send_frame(8'hFF, 16'd2, 1'b1, -1);
    send_frame(scfp_pkg::CmdPing, 16'd2001, 1'b0, -1);
    send_frame(scfp_pkg::CmdPing, 16'hFFFF, 1'b0, -1);
    hold_req = 1'b1;
    run_random(120, 1'b1);
    settle_idle();

    // Zero marker, length limit zero so only empty frames pass, checksum enforced
    write_reg(scfp_pkg::RegStart, 32'h00);
    write_reg(scfp_pkg::RegMaxLen, 32'd0);
    write_reg(scfp_pkg::RegCsEnf, 32'd1);
    run_random(50, 1'b0);
    settle_idle();

    // Full-scale marker and length limit, back-to-back with no stalls
    write_reg(scfp_pkg::RegStart, 32'hFF);
    write_reg(scfp_pkg::RegMaxLen, 32'hFFFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(100, 1'b1);
    settle_idle();
    tx_idle_pct = 34;
    rx_idle_pct = 34;

    write_reg(scfp_pkg::RegStart, 32'($urandom_range(0, 255)));
    write_reg(scfp_pkg::RegMaxLen, 32'($urandom_range(1, 40)));
    write_reg(scfp_pkg::RegCsEnf, 32'd0);
    run_random(100, 1'b0);
    settle_idle();

    write_reg(scfp_pkg::RegStart, 32'(scfp_pkg::StartReset));
    write_reg(scfp_pkg::RegMaxLen, 32'd5);
    write_reg(scfp_pkg::RegCsEnf, 32'($urandom_range(0, 1)));
    run_random(60, 1'b0);
    settle_idle();

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
